// ===== hw/rtl/hkv_pkg.sv =====
// hkv_pkg: sizes, codes and word types for the hashed key/value store
// used by every file under hw/rtl; depends on nothing
package hkv_pkg;

   localparam int NUM_BUCKETS     = 16;   // power of two, bucket taken from key low bits
   localparam int WAYS_PER_BUCKET = 4;
   localparam int KEY_BITS        = 32;
   localparam int VALUE_BITS      = 32;

   localparam int SLOT_COUNT  = NUM_BUCKETS * WAYS_PER_BUCKET;
   localparam int BUCKET_BITS = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int WAY_BITS    = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
   localparam int COUNT_BITS  = 7;

   typedef enum logic [1:0] {
      ACT_PUT    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_GET    = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_KEY   = 2'd3
   } status_type;

   typedef struct packed {
      action_type             action;
      logic [KEY_BITS-1:0]    key;
      logic [VALUE_BITS-1:0]  value_in;
   } req_word_type;

   typedef struct packed {
      status_type             status;
      logic                   found;
      logic [VALUE_BITS-1:0]  value_out;
      logic [COUNT_BITS-1:0]  entry_count;
   } rsp_word_type;

   // one way of a bucket row as held in the memory
   typedef struct packed {
      logic [KEY_BITS-1:0]    key;
      logic [VALUE_BITS-1:0]  value;
   } way_entry_type;

   typedef way_entry_type [WAYS_PER_BUCKET-1:0] bucket_row_type;
   typedef logic [WAYS_PER_BUCKET-1:0]          way_mask_type;

   // outcome of the parallel way compare
   typedef struct packed {
      logic                 hit;
      logic [WAY_BITS-1:0]  hit_way;
      logic                 has_free;
      logic [WAY_BITS-1:0]  free_way;
   } match_type;

endpackage

// ===== hw/rtl/hashed_key_value_store.sv =====
// hashed_key_value_store: top level of the bucketed key/value map
// depends on hkv_pkg, hkv_bucket_ram and hkv_way_match
//
//   channel   direction   handshake             word
//   req       in          req_valid/req_stall   req_word_type (action, key, value_in)
//   rsp       out         rsp_valid/rsp_stall   rsp_word_type (status, found, value_out,
//                                                              entry_count)
//
// each request is taken in the idle state, and the accept edge reads its bucket row from the
// memory; the update state then compares all ways and writes the row back once the output is free
// one request is in flight at a time; the single memory read-modify-write sets this
// the result sits in an output register, so a new request is taken while it waits
// a stalled result holds back only the commit of the following request
// reset clears the valid bits and the count at once; no clearing pass is needed
module hashed_key_value_store import hkv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_word_type  req_word,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_word_type  rsp_word
);

   typedef enum logic [1:0] {
      FSM_IDLE   = 2'b01,
      FSM_UPDATE = 2'b10
   } fsm_type;

   fsm_type                                  state_ff, state_in;
   req_word_type                             req_ff;
   rsp_word_type                             rsp_ff, rsp_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]                    count_ff, count_in;
   logic [NUM_BUCKETS-1:0][WAYS_PER_BUCKET-1:0] valid_ff, valid_in;

   logic                    req_accept;
   logic                    out_free;
   logic                    commit;
   logic [BUCKET_BITS-1:0]  bucket;
   bucket_row_type          rd_row;
   bucket_row_type          wr_row;
   logic                    wr_want;
   match_type               match;

   assign req_stall  = (state_ff != FSM_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign commit     = (state_ff == FSM_UPDATE) && out_free;
   assign bucket     = req_ff.key[BUCKET_BITS-1:0];

   // bucket rows
   hkv_bucket_ram u_ram (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (req_word.key[BUCKET_BITS-1:0]),
      .rd_row  (rd_row),
      .wr_en   (commit && wr_want),
      .wr_addr (bucket),
      .wr_row  (wr_row)
   );

   // way compare
   hkv_way_match u_match (
      .row    (rd_row),
      .valid  (valid_ff[bucket]),
      .key    (req_ff.key),
      .result (match)
   );

   // request decode and row modification
   always_comb begin
      rsp_in             = '0;
      rsp_in.status      = ST_OK;
      valid_in           = valid_ff;
      count_in           = count_ff;
      wr_row             = rd_row;
      wr_want            = 1'b0;
      case (req_ff.action)
         ACT_CLEAR: begin
            valid_in = '0;
            count_in = '0;
         end
         ACT_PUT, ACT_REMOVE, ACT_GET: begin
            if (req_ff.key == '0) begin
               rsp_in.status = ST_BAD_KEY;
            end else begin
               rsp_in.found = match.hit;
               case (req_ff.action)
                  ACT_PUT: begin
                     if (match.hit) begin
                        wr_row[match.hit_way].value = req_ff.value_in;
                        wr_want = 1'b1;
                     end else if (match.has_free) begin
                        wr_row[match.free_way].key   = req_ff.key;
                        wr_row[match.free_way].value = req_ff.value_in;
                        wr_want = 1'b1;
                        valid_in[bucket][match.free_way] = 1'b1;
                        count_in = count_ff + COUNT_BITS'(1);
                     end else begin
                        rsp_in.status = ST_FULL;
                     end
                  end
                  ACT_REMOVE: begin
                     if (match.hit) begin
                        valid_in[bucket][match.hit_way] = 1'b0;
                        if (count_ff != '0) begin
                           count_in = count_ff - COUNT_BITS'(1);
                        end
                     end else begin
                        rsp_in.status = ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     if (match.hit) begin
                        rsp_in.value_out = rd_row[match.hit_way].value;
                     end else begin
                        rsp_in.status = ST_NOT_FOUND;
                     end
                  end
               endcase
            end
         end
         default: begin
            rsp_in.status = ST_OK;
         end
      endcase
      rsp_in.entry_count = count_in;
   end

   // sequencing
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         FSM_IDLE: begin
            if (req_accept) begin
               state_in = FSM_UPDATE;
            end
         end
         FSM_UPDATE: begin
            if (commit) begin
               state_in     = FSM_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            count_ff <= count_in;
            valid_ff <= valid_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_word;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // count tracks the valid bits
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == COUNT_BITS'($countones(valid_ff)))
      else $error("entry count differs from number of valid ways");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(SLOT_COUNT))
      else $error("entry count above slot count");

   // a result only appears out of the update cycle
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FSM_UPDATE))
      else $error("result raised without an update");

   // rejected keys leave the table alone
   a_bad_key_no_change: assert property (@(posedge clock) disable iff (reset)
      (commit && req_ff.key == '0 && req_ff.action != ACT_CLEAR)
      |=> (valid_ff == $past(valid_ff)) && (count_ff == $past(count_ff)))
      else $error("zero key changed the table");

endmodule

// ===== hw/rtl/hkv_bucket_ram.sv =====
// hkv_bucket_ram: one row per bucket holding the keys and values of all ways
// depends on hkv_pkg; single write port, single read port, registered read
module hkv_bucket_ram import hkv_pkg::*; (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [BUCKET_BITS-1:0]  rd_addr,
   output bucket_row_type          rd_row,
   input  logic                    wr_en,
   input  logic [BUCKET_BITS-1:0]  wr_addr,
   input  bucket_row_type          wr_row
);

   bucket_row_type mem [NUM_BUCKETS];
   bucket_row_type rd_row_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

// ===== hw/rtl/hkv_way_match.sv =====
// hkv_way_match: compares a key against every way of one bucket at once
// depends on hkv_pkg; lowest-numbered hit and lowest free way win
module hkv_way_match import hkv_pkg::*; (
   input  bucket_row_type        row,
   input  way_mask_type          valid,
   input  logic [KEY_BITS-1:0]   key,
   output match_type             result
);

   // scan from the top so the lowest way is left standing
   always_comb begin
      result = '0;
      for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--) begin
         if (valid[w]) begin
            if (row[w].key == key) begin
               result.hit     = 1'b1;
               result.hit_way = WAY_BITS'(w);
            end
         end else begin
            result.has_free = 1'b1;
            result.free_way = WAY_BITS'(w);
         end
      end
   end

endmodule

// ===== tb/sv/hashed_key_value_store_tb.sv =====
`timescale 1ns / 1ps
// hashed_key_value_store_tb: self-checking bench for the bucketed key/value map
// depends on hkv_pkg and hashed_key_value_store; holds its own copy of the table
module hashed_key_value_store_tb;
   import hkv_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // shadow copy of the table
   logic                    map_valid [SLOT_COUNT];
   logic [KEY_BITS-1:0]     map_key   [SLOT_COUNT];
   logic [VALUE_BITS-1:0]   map_value [SLOT_COUNT];
   int                      map_count = 0;

   rsp_word_type            pending_rsps [$];
   logic [KEY_BITS-1:0]     key_pool [20];
   logic [KEY_BITS-1:0]     fill_keys [SLOT_COUNT];

   bit  idle_on = 1'b1;
   int  hold_request = 0;
   int  hold_left = 0;
   int  mismatches = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  full_puts = 0;
   int  peak_count = 0;

   hashed_key_value_store uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400_000;
      $display("hashed_key_value_store verification failed");
      $finish;
   end

   // apply one request to the shadow table and give the result it should produce
   function automatic rsp_word_type map_apply(req_word_type w);
      rsp_word_type r;
      int           base;
      int           hit_slot;
      int           free_slot;
      r         = '0;
      r.status  = ST_OK;
      hit_slot  = -1;
      free_slot = -1;
      if (w.action == ACT_CLEAR) begin
         for (int i = 0; i < SLOT_COUNT; i++) map_valid[i] = 1'b0;
         map_count = 0;
      end else if (w.key == '0) begin
         r.status = ST_BAD_KEY;
      end else begin
         base = int'(w.key % NUM_BUCKETS) * WAYS_PER_BUCKET;
         for (int way = 0; way < WAYS_PER_BUCKET; way++) begin
            if (map_valid[base + way]) begin
               if (hit_slot < 0 && map_key[base + way] == w.key) hit_slot = base + way;
            end else if (free_slot < 0) begin
               free_slot = base + way;
            end
         end
         r.found = (hit_slot >= 0);
         case (w.action)
            ACT_PUT: begin
               if (hit_slot >= 0) begin
                  map_value[hit_slot] = w.value_in;
               end else if (free_slot >= 0) begin
                  map_valid[free_slot] = 1'b1;
                  map_key[free_slot]   = w.key;
                  map_value[free_slot] = w.value_in;
                  map_count++;
               end else begin
                  r.status = ST_FULL;
               end
            end
            ACT_REMOVE: begin
               if (hit_slot >= 0) begin
                  map_valid[hit_slot] = 1'b0;
                  if (map_count > 0) map_count--;
               end else begin
                  r.status = ST_NOT_FOUND;
               end
            end
            default: begin
               if (hit_slot >= 0) r.value_out = map_value[hit_slot];
               else r.status = ST_NOT_FOUND;
            end
         endcase
      end
      r.entry_count = map_count[COUNT_BITS-1:0];
      return r;
   endfunction

   // offer one word, wait for it to be taken, then log what it should return
   task automatic send_request(action_type act, logic [KEY_BITS-1:0] k,
                               logic [VALUE_BITS-1:0] v);
      req_word_type w;
      rsp_word_type want;
      w.action   = act;
      w.key      = k;
      w.value_in = v;
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      want = map_apply(w);
      pending_rsps.push_back(want);
      words_sent++;
      if (want.status == ST_FULL) full_puts++;
      if (map_count > peak_count) peak_count = map_count;
   endtask

   // stop offering and wait until every result is back
   task automatic drain_rsps();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // receiver: random stalls, or a long counted hold-off on request
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 20);
      end
   end

   // compare each taken result with the oldest outstanding one
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         words_checked++;
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: status %0d found %0d value %h count %0d",
                        rsp_word.status, rsp_word.found, rsp_word.value_out,
                        rsp_word.entry_count);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_word.status !== want.status || rsp_word.found !== want.found ||
                rsp_word.value_out !== want.value_out ||
                rsp_word.entry_count !== want.entry_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: expected status %0d found %0d value %h count %0d, %s",
                           $realtime, want.status, want.found, want.value_out,
                           want.entry_count, "see next line");
               if (mismatches <= 10)
                  $display("   actual status %0d found %0d value %h count %0d",
                           rsp_word.status, rsp_word.found, rsp_word.value_out,
                           rsp_word.entry_count);
            end
         end
      end
   end

   // keys that crowd a few buckets, so hits, misses and full buckets all occur
   task automatic refresh_key_pool();
      logic [3:0] hot [4];
      for (int i = 0; i < 4; i++) hot[i] = 4'($urandom);
      for (int i = 0; i < 20; i++) begin
         key_pool[i] = {28'($urandom), hot[$urandom_range(3)]};
         if (key_pool[i] == '0) key_pool[i][KEY_BITS-1] = 1'b1;
      end
   endtask

   function automatic logic [KEY_BITS-1:0] pick_key();
      int roll;
      roll = $urandom_range(99);
      if (roll < 4) return '0;
      if (roll < 14) return $urandom;
      return key_pool[$urandom_range(19)];
   endfunction

   function automatic action_type pick_action();
      int roll;
      roll = $urandom_range(99);
      if (roll < 42) return ACT_PUT;
      if (roll < 64) return ACT_REMOVE;
      if (roll < 98) return ACT_GET;
      return ACT_CLEAR;
   endfunction

   // corner words: zero key, all-ones key and value, replace, full bucket, clear
   task automatic test_directed_edges();
      send_request(ACT_GET,    32'h0000_0005, 32'h0);
      send_request(ACT_REMOVE, 32'h0000_0005, 32'h0);
      send_request(ACT_PUT,    32'h0,         32'hdead_beef);
      send_request(ACT_GET,    32'h0,         32'h0);
      send_request(ACT_REMOVE, 32'h0,         32'hffff_ffff);
      send_request(ACT_PUT,    32'hffff_ffff, 32'hffff_ffff);
      send_request(ACT_GET,    32'hffff_ffff, 32'h0);
      send_request(ACT_PUT,    32'hffff_ffff, 32'h0);
      send_request(ACT_GET,    32'hffff_ffff, 32'h1234_5678);
      // fill bucket one, then overflow it
      send_request(ACT_PUT,    32'h0000_0001, 32'h1111_1111);
      send_request(ACT_PUT,    32'h0000_0011, 32'h2222_2222);
      send_request(ACT_PUT,    32'h0000_0021, 32'h3333_3333);
      send_request(ACT_PUT,    32'h8000_0001, 32'h4444_4444);
      send_request(ACT_PUT,    32'h0000_0041, 32'h5555_5555);
      send_request(ACT_PUT,    32'h0000_0021, 32'haaaa_aaaa);
      send_request(ACT_REMOVE, 32'h0000_0011, 32'h0);
      send_request(ACT_PUT,    32'h0000_0041, 32'h5555_5555);
      send_request(ACT_GET,    32'h0000_0041, 32'h0);
      send_request(ACT_REMOVE, 32'h0000_0011, 32'h0);
      send_request(ACT_CLEAR,  32'h0,         32'h0);
      send_request(ACT_GET,    32'h0000_0021, 32'h0);
      send_request(ACT_CLEAR,  32'hffff_ffff, 32'hffff_ffff);
      drain_rsps();
   endtask

   // every way of every bucket taken, count at its top, then read back
   task automatic test_fill_table();
      logic [25:0] upper;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
         for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
            upper = 26'($urandom);
            upper[0] = 1'b1;
            fill_keys[b * WAYS_PER_BUCKET + w] = {upper, 2'(w), 4'(b)};
            send_request(ACT_PUT, fill_keys[b * WAYS_PER_BUCKET + w], $urandom);
         end
      end
      send_request(ACT_PUT, {28'($urandom) | 28'h1, 4'($urandom)}, $urandom);
      for (int i = 0; i < SLOT_COUNT; i++)
         send_request(ACT_GET, fill_keys[$urandom_range(SLOT_COUNT - 1)], $urandom);
      for (int i = 0; i < 6; i++)
         send_request(ACT_REMOVE, fill_keys[$urandom_range(SLOT_COUNT - 1)], $urandom);
      send_request(ACT_CLEAR, $urandom, $urandom);
      drain_rsps();
   endtask

   // result side held off for a long stretch while requests keep coming
   task automatic test_backpressure();
      refresh_key_pool();
      hold_request = 150;
      for (int i = 0; i < 20; i++) send_request(pick_action(), pick_key(), $urandom);
      drain_rsps();
   endtask

   task automatic test_random_traffic(int count, bit with_idle);
      refresh_key_pool();
      idle_on = with_idle;
      for (int i = 0; i < count; i++) send_request(pick_action(), pick_key(), $urandom);
      drain_rsps();
      idle_on = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         map_valid[i] = 1'b0;
         map_key[i]   = '0;
         map_value[i] = '0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_fill_table();
      test_backpressure();
      test_random_traffic(240, 1'b1);
      test_random_traffic(240, 1'b0);
      test_random_traffic(240, 1'b1);

      $display("run covered %0d request words and %0d checked result words", words_sent,
               words_checked);
      $display("full-bucket puts %0d, peak of %0d stored entries, %0d mismatches",
               full_puts, peak_count, mismatches);
      if (mismatches == 0 && pending_rsps.size() == 0) begin
         $display("hashed_key_value_store verification clean");
      end else begin
         $display("hashed_key_value_store verification failed");
      end
      $finish;
   end

endmodule
